@@ rtl/oerb_pkg.sv @@
// Shared types and constants of the overwriting event ring buffer.
package oerb_pkg;

    localparam int TS_W             = 32;
    localparam int EVENT_W          = 16;
    localparam int LEVEL_W          = 8;
    localparam int ARG_W            = 32;
    localparam int COUNT_W          = 7;
    localparam int DROP_W           = 32;
    localparam int DEFAULT_RING_DEPTH = 64;
    localparam int CMD_QUEUE_DEPTH  = 2;

    typedef enum logic {
        KIND_RECORD = 1'b0,
        KIND_DRAIN  = 1'b1
    } kind_t;

    typedef struct packed {
        logic [TS_W-1:0]    ts;
        logic [EVENT_W-1:0] evt_code;
        logic [LEVEL_W-1:0] level;
        logic [ARG_W-1:0]   arg_first;
        logic [ARG_W-1:0]   arg_second;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        kind_t              kind;
        entry_t             entry;
        logic [COUNT_W-1:0] drain_limit;
        logic               read_dropped;
    } cmd_t;

    typedef struct packed {
        logic               has_entry;
        entry_t             entry;
        logic [DROP_W-1:0]  dropped_count;
        logic [COUNT_W-1:0] entries_left;
        logic               last;
    } res_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_STREAM,
        ENG_EMPTY
    } eng_state_t;

endpackage

@@ rtl/oerb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module oerb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/oerb_front.sv @@
// Front end: accepts input transfers, forms commands and queues them for the engine.
module oerb_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [oerb_pkg::TS_W-1:0]     s_timestamp_ms,
    input  logic [oerb_pkg::EVENT_W-1:0]  s_evt_code,
    input  logic [oerb_pkg::LEVEL_W-1:0]  s_level,
    input  logic [oerb_pkg::ARG_W-1:0]    s_arg_first,
    input  logic [oerb_pkg::ARG_W-1:0]    s_arg_second,
    input  logic [oerb_pkg::COUNT_W-1:0]  s_drain_limit,
    input  logic                          s_read_dropped,
    output logic                          cmd_valid,
    output oerb_pkg::cmd_t                cmd,
    input  logic                          cmd_pop
);

    import oerb_pkg::*;

    localparam int QIDX_W = $clog2(CMD_QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

    cmd_t              slot_reg [CMD_QUEUE_DEPTH];
    logic [QIDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [QIDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    cmd_t              in_cmd;
    logic              push;

    always_comb begin
        in_cmd              = '0;
        in_cmd.kind         = kind_t'(s_kind);
        if (in_cmd.kind == KIND_RECORD) begin
            in_cmd.entry.ts         = s_timestamp_ms;
            in_cmd.entry.evt_code   = s_evt_code;
            in_cmd.entry.level      = s_level;
            in_cmd.entry.arg_first  = s_arg_first;
            in_cmd.entry.arg_second = s_arg_second;
        end else begin
            in_cmd.drain_limit  = s_drain_limit;
            in_cmd.read_dropped = s_read_dropped;
        end
    end

    assign s_ready   = (count_reg != QCNT_W'(CMD_QUEUE_DEPTH));
    assign push      = s_valid && s_ready;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = slot_reg[rd_idx_reg];

    always_comb begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = count_reg;
        if (push) begin
            wr_idx_next = (wr_idx_reg == QIDX_W'(CMD_QUEUE_DEPTH - 1)) ? '0
                        : wr_idx_reg + QIDX_W'(1);
        end
        if (cmd_pop) begin
            rd_idx_next = (rd_idx_reg == QIDX_W'(CMD_QUEUE_DEPTH - 1)) ? '0
                        : rd_idx_reg + QIDX_W'(1);
        end
        if (push && !cmd_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (!push && cmd_pop) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_idx_reg] <= in_cmd;
        end
    end

endmodule

@@ rtl/oerb_engine.sv @@
// Back end: owns the ring, executes record and drain commands, drives the result register.
module oerb_engine #(
    parameter int RING_DEPTH = oerb_pkg::DEFAULT_RING_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cmd_valid,
    input  oerb_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output oerb_pkg::res_t m_res
);

    import oerb_pkg::*;

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);

    eng_state_t        state_reg, state_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [DROP_W-1:0] dropped_reg, dropped_next;
    logic [FILL_W-1:0] issue_left_reg, issue_left_next;
    logic [FILL_W-1:0] emit_left_reg, emit_left_next;
    logic              pending_reg, pending_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg, out_next;
    logic [DROP_W-1:0] drain_dropped_reg, drain_dropped_next;
    logic [FILL_W-1:0] drain_left_reg, drain_left_next;

    logic              ram_we;
    logic              ram_re;
    entry_t            ram_rdata;
    logic              can_load;
    logic              load;
    logic              issue;
    logic              req_nz;
    logic [FILL_W-1:0] num;
    logic [FILL_W-1:0] left;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    oerb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (cmd.entry),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign can_load = !out_valid_reg || m_ready;
    assign load     = (state_reg == ENG_STREAM) && pending_reg && can_load;
    assign issue    = (state_reg == ENG_STREAM) && (issue_left_reg != '0)
                   && (!pending_reg || can_load);
    assign req_nz   = (cmd.drain_limit != '0);
    assign num      = !req_nz ? '0
                    : (COUNT_W'(fill_reg) < cmd.drain_limit) ? fill_reg
                    : FILL_W'(cmd.drain_limit);
    assign left     = fill_reg - num;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ENG_IDLE: begin
                if (cmd_valid && cmd.kind == KIND_DRAIN) begin
                    state_next = (num == '0) ? ENG_EMPTY : ENG_STREAM;
                end
            end
            ENG_STREAM: begin
                if (load && emit_left_reg == FILL_W'(1)) begin
                    state_next = ENG_IDLE;
                end
            end
            ENG_EMPTY: begin
                if (can_load) begin
                    state_next = ENG_IDLE;
                end
            end
            default: state_next = ENG_IDLE;
        endcase
    end

    always_comb begin
        cmd_pop            = 1'b0;
        ram_we             = 1'b0;
        ram_re             = issue;
        wr_ptr_next        = wr_ptr_reg;
        rd_ptr_next        = rd_ptr_reg;
        fill_next          = fill_reg;
        dropped_next       = dropped_reg;
        issue_left_next    = issue_left_reg;
        emit_left_next     = emit_left_reg;
        pending_next       = pending_reg;
        out_valid_next     = out_valid_reg && !m_ready;
        out_next           = out_reg;
        drain_dropped_next = drain_dropped_reg;
        drain_left_next    = drain_left_reg;
        unique case (state_reg)
            ENG_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    if (cmd.kind == KIND_RECORD) begin
                        ram_we      = 1'b1;
                        wr_ptr_next = ring_next(wr_ptr_reg);
                        if (fill_reg == FILL_W'(RING_DEPTH)) begin
                            rd_ptr_next  = ring_next(rd_ptr_reg);
                            dropped_next = dropped_reg + DROP_W'(1);
                        end else begin
                            fill_next = fill_reg + FILL_W'(1);
                        end
                    end else begin
                        fill_next          = left;
                        drain_left_next    = left;
                        issue_left_next    = num;
                        emit_left_next     = num;
                        pending_next       = 1'b0;
                        drain_dropped_next = '0;
                        if (req_nz && cmd.read_dropped) begin
                            drain_dropped_next = dropped_reg;
                            dropped_next       = '0;
                        end
                    end
                end
            end
            ENG_STREAM: begin
                if (issue) begin
                    rd_ptr_next     = ring_next(rd_ptr_reg);
                    issue_left_next = issue_left_reg - FILL_W'(1);
                    pending_next    = 1'b1;
                end else if (load) begin
                    pending_next = 1'b0;
                end
                if (load) begin
                    out_valid_next         = 1'b1;
                    out_next.has_entry     = 1'b1;
                    out_next.entry         = ram_rdata;
                    out_next.dropped_count = drain_dropped_reg;
                    out_next.entries_left  = COUNT_W'(drain_left_reg);
                    out_next.last          = (emit_left_reg == FILL_W'(1));
                    emit_left_next         = emit_left_reg - FILL_W'(1);
                end
            end
            ENG_EMPTY: begin
                if (can_load) begin
                    out_valid_next         = 1'b1;
                    out_next.has_entry     = 1'b0;
                    out_next.entry         = '0;
                    out_next.dropped_count = drain_dropped_reg;
                    out_next.entries_left  = COUNT_W'(drain_left_reg);
                    out_next.last          = 1'b1;
                end
            end
            default: begin
                out_valid_next = out_valid_reg && !m_ready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ENG_IDLE;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fill_reg       <= '0;
            dropped_reg    <= '0;
            issue_left_reg <= '0;
            emit_left_reg  <= '0;
            pending_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            fill_reg       <= fill_next;
            dropped_reg    <= dropped_next;
            issue_left_reg <= issue_left_next;
            emit_left_reg  <= emit_left_next;
            pending_reg    <= pending_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg           <= out_next;
        drain_dropped_reg <= drain_dropped_next;
        drain_left_reg    <= drain_left_next;
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_reg;

endmodule

@@ rtl/overwriting_event_ring_buffer_unit.sv @@
// Top level of the overwriting event ring buffer: command queue, ring engine, checks.
//
//  channel | direction | transfer when       | carries
//  s_      | in        | s_valid && s_ready  | record or drain command
//  m_      | out       | m_valid && m_ready  | one drain result (entry or empty)
//
// A record is written to the ring in the cycle the engine pops it; the queue registers each command.
// A drain of n entries streams one result per cycle after the first RAM read while m_ready
// is held high; an empty drain gives one empty result. The RAM read port sets the stream rate.
// Reset (aresetn low, synchronous) empties the queue, ring pointers and counters.
// A stalled result holds a drain in progress; records wait in the queue behind it, and the
// two-entry queue keeps taking transfers until it fills.
module overwriting_event_ring_buffer_unit #(
    parameter int RING_DEPTH = oerb_pkg::DEFAULT_RING_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [oerb_pkg::TS_W-1:0]     s_timestamp_ms,
    input  logic [oerb_pkg::EVENT_W-1:0]  s_evt_code,
    input  logic [oerb_pkg::LEVEL_W-1:0]  s_level,
    input  logic [oerb_pkg::ARG_W-1:0]    s_arg_first,
    input  logic [oerb_pkg::ARG_W-1:0]    s_arg_second,
    input  logic [oerb_pkg::COUNT_W-1:0]  s_drain_limit,
    input  logic                          s_read_dropped,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_has_entry,
    output logic [oerb_pkg::TS_W-1:0]     m_entry_time,
    output logic [oerb_pkg::EVENT_W-1:0]  m_entry_event,
    output logic [oerb_pkg::LEVEL_W-1:0]  m_entry_level,
    output logic [oerb_pkg::ARG_W-1:0]    m_entry_arg_first,
    output logic [oerb_pkg::ARG_W-1:0]    m_entry_arg_second,
    output logic [oerb_pkg::DROP_W-1:0]   m_dropped_count,
    output logic [oerb_pkg::COUNT_W-1:0]  m_entries_left,
    output logic                          m_last
);

    import oerb_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;
    res_t res;

    oerb_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_timestamp_ms (s_timestamp_ms),
        .s_evt_code     (s_evt_code),
        .s_level        (s_level),
        .s_arg_first    (s_arg_first),
        .s_arg_second   (s_arg_second),
        .s_drain_limit  (s_drain_limit),
        .s_read_dropped (s_read_dropped),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop)
    );

    oerb_engine #(
        .RING_DEPTH (RING_DEPTH)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (res)
    );

    assign m_has_entry        = res.has_entry;
    assign m_entry_time       = res.entry.ts;
    assign m_entry_event      = res.entry.evt_code;
    assign m_entry_level      = res.entry.level;
    assign m_entry_arg_first  = res.entry.arg_first;
    assign m_entry_arg_second = res.entry.arg_second;
    assign m_dropped_count    = res.dropped_count;
    assign m_entries_left     = res.entries_left;
    assign m_last             = res.last;

    a_pop_needs_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> cmd_valid)
        else $error("engine popped an empty command queue");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_entry |-> m_last && m_entry_time == '0
            && m_entry_event == '0 && m_entry_arg_first == '0)
        else $error("empty drain result is not last or carries entry data");

    a_drain_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid && m_has_entry
            && $stable(m_dropped_count) && $stable(m_entries_left))
        else $error("drain stream broke or changed its summary fields");

endmodule

@@ tb/tb_overwriting_event_ring_buffer_unit.sv @@
// Self-checking testbench for the overwriting event ring buffer: records, drains and overwrites.
`timescale 1ns / 1ps

module tb_overwriting_event_ring_buffer_unit;
    import oerb_pkg::*;

    localparam int DEPTH       = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_TAIL  = 40;

    class ring_scoreboard;
        entry_t ring [DEPTH];
        int     wr_ptr;
        int     rd_ptr;
        int     fill;
        logic [DROP_W-1:0] dropped = '0;
        res_t   pending [$];
        int     errors;
        int     records;
        int     overwrites;
        int     drains;
        int     empty_drains;
        int     entries_out;
        int     dropped_reads;

        function int ring_next(int p);
            return (p == DEPTH - 1) ? 0 : p + 1;
        endfunction

        function void note_command(kind_t kind, entry_t e, logic [COUNT_W-1:0] max_req,
                                   logic want_dropped);
            res_t r;
            logic [DROP_W-1:0] dropped_out;
            int num;
            int left;
            if (kind == KIND_RECORD) begin
                records++;
                if (fill >= DEPTH) begin
                    rd_ptr = ring_next(rd_ptr);
                    dropped = dropped + 1;
                    overwrites++;
                end else begin
                    fill++;
                end
                ring[wr_ptr] = e;
                wr_ptr = ring_next(wr_ptr);
                return;
            end
            drains++;
            dropped_out = '0;
            num = 0;
            if (max_req != 0) begin
                if (want_dropped) begin
                    dropped_out = dropped;
                    dropped = '0;
                    if (dropped_out != 0) dropped_reads++;
                end
                num = (fill < int'(max_req)) ? fill : int'(max_req);
            end
            left = fill - num;
            for (int i = 0; i < num; i++) begin
                r.has_entry     = 1'b1;
                r.entry         = ring[rd_ptr];
                r.dropped_count = dropped_out;
                r.entries_left  = COUNT_W'(left);
                r.last          = (i == num - 1);
                pending.push_back(r);
                rd_ptr = ring_next(rd_ptr);
            end
            fill = left;
            entries_out += num;
            if (num == 0) begin
                empty_drains++;
                r.has_entry     = 1'b0;
                r.entry         = '0;
                r.dropped_count = dropped_out;
                r.entries_left  = COUNT_W'(left);
                r.last          = 1'b1;
                pending.push_back(r);
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (seen !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, seen);
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transfer, expected none actual %h",
                         $time, got);
                return;
            end
            want = pending.pop_front();
            compare_field("has_entry", 32'(want.has_entry), 32'(got.has_entry));
            compare_field("entry_time", want.entry.ts, got.entry.ts);
            compare_field("entry_event", 32'(want.entry.evt_code), 32'(got.entry.evt_code));
            compare_field("entry_level", 32'(want.entry.level), 32'(got.entry.level));
            compare_field("entry_arg_first", want.entry.arg_first, got.entry.arg_first);
            compare_field("entry_arg_second", want.entry.arg_second, got.entry.arg_second);
            compare_field("dropped_count", want.dropped_count, got.dropped_count);
            compare_field("entries_left", 32'(want.entries_left), 32'(got.entries_left));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_kind = KIND_RECORD;
    logic [TS_W-1:0]     s_timestamp_ms = '0;
    logic [EVENT_W-1:0]  s_evt_code = '0;
    logic [LEVEL_W-1:0]  s_level = '0;
    logic [ARG_W-1:0]    s_arg_first = '0;
    logic [ARG_W-1:0]    s_arg_second = '0;
    logic [COUNT_W-1:0]  s_drain_limit = '0;
    logic                s_read_dropped = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_has_entry;
    logic [TS_W-1:0]     m_entry_time;
    logic [EVENT_W-1:0]  m_entry_event;
    logic [LEVEL_W-1:0]  m_entry_level;
    logic [ARG_W-1:0]    m_entry_arg_first;
    logic [ARG_W-1:0]    m_entry_arg_second;
    logic [DROP_W-1:0]   m_dropped_count;
    logic [COUNT_W-1:0]  m_entries_left;
    logic                m_last;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;
    ring_scoreboard board = new;

    overwriting_event_ring_buffer_unit #(.RING_DEPTH(DEPTH)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_timestamp_ms(s_timestamp_ms), .s_evt_code(s_evt_code), .s_level(s_level),
        .s_arg_first(s_arg_first), .s_arg_second(s_arg_second),
        .s_drain_limit(s_drain_limit), .s_read_dropped(s_read_dropped),
        .m_valid(m_valid), .m_ready(m_ready), .m_has_entry(m_has_entry),
        .m_entry_time(m_entry_time), .m_entry_event(m_entry_event),
        .m_entry_level(m_entry_level), .m_entry_arg_first(m_entry_arg_first),
        .m_entry_arg_second(m_entry_arg_second), .m_dropped_count(m_dropped_count),
        .m_entries_left(m_entries_left), .m_last(m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                board.note_command(kind_t'(s_kind),
                    {s_timestamp_ms, s_evt_code, s_level, s_arg_first, s_arg_second},
                    s_drain_limit, s_read_dropped);
            if (m_valid && m_ready)
                board.check_result({m_has_entry, m_entry_time, m_entry_event, m_entry_level,
                    m_entry_arg_first, m_entry_arg_second, m_dropped_count, m_entries_left,
                    m_last});
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, board.pending.size());
            $display("overwriting_event_ring_buffer_unit verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic entry_t random_entry();
        entry_t e;
        e.ts         = pick_word();
        e.evt_code   = EVENT_W'(pick_word());
        e.level      = LEVEL_W'(pick_word());
        e.arg_first  = pick_word();
        e.arg_second = pick_word();
        return e;
    endfunction

    function automatic logic [COUNT_W-1:0] pick_drain_size();
        int r;
        r = $urandom_range(19);
        if (r == 0) return '0;
        if (r <= 2) return COUNT_W'($urandom_range(65, 127));
        if (r <= 6) return COUNT_W'($urandom_range(9, 64));
        return COUNT_W'($urandom_range(1, 8));
    endfunction

    task automatic send_command(kind_t kind, entry_t e, logic [COUNT_W-1:0] max_req,
                                logic want_dropped);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_timestamp_ms <= e.ts;
        s_evt_code     <= e.evt_code;
        s_level        <= e.level;
        s_arg_first    <= e.arg_first;
        s_arg_second   <= e.arg_second;
        s_drain_limit  <= max_req;
        s_read_dropped <= want_dropped;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (board.pending.size() != 0);
    endtask

    task automatic send_record();
        send_command(KIND_RECORD, random_entry(), COUNT_W'($urandom), 1'($urandom));
    endtask

    task automatic run_random_phase(int items_goal, bit open_with_overflow);
        int sent;
        int burst;
        sent = 0;
        while (sent < items_goal) begin
            case ($urandom_range(9))
                0:       burst = 0;
                1:       burst = $urandom_range(60, 90);
                default: burst = $urandom_range(1, 12);
            endcase
            if (open_with_overflow && sent == 0) burst = 70;
            for (int i = 0; i < burst && sent < items_goal - 1; i++) begin
                send_record();
                sent++;
            end
            send_command(KIND_DRAIN, random_entry(),
                         (open_with_overflow && sent == 70) ? COUNT_W'(DEPTH) : pick_drain_size(),
                         ($urandom_range(3) != 0));
            sent++;
        end
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 25;
        recv_idle_pct = 49;
        // empty ring: zero and nonzero request
        send_command(KIND_DRAIN, '1, '0, 1'b1);
        send_command(KIND_DRAIN, '1, COUNT_W'(1), 1'b1);
        send_command(KIND_RECORD, '0, '1, 1'b1);
        send_command(KIND_RECORD, '1, '0, 1'b0);
        send_command(KIND_RECORD,
                     '{32'hAAAA_AAAA, 16'h5555, 8'hA5, 32'h5555_5555, 32'hAAAA_AAAA}, '0, 1'b0);
        send_command(KIND_DRAIN, '0, '1, 1'b0);
        send_record();
        send_record();
        send_command(KIND_DRAIN, '0, '0, 1'b1);
        send_command(KIND_DRAIN, '0, COUNT_W'(1), 1'b0);
        send_command(KIND_DRAIN, '0, COUNT_W'(DEPTH), 1'b1);
        send_command(KIND_DRAIN, '0, COUNT_W'(DEPTH), 1'b0);
        hold_until_drained();

        run_random_phase(137, 1'b1);
        hold_until_drained();
        send_idle_pct = 49;
        recv_idle_pct = 25;
        run_random_phase(137, 1'b0);
        hold_until_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(137, 1'b0);

        hold_until_drained();
        repeat (DRAIN_TAIL) @(negedge aclk);

        $display("covered %0d records (%0d overwrites), %0d drains (%0d empty)",
                 board.records, board.overwrites, board.drains, board.empty_drains);
        $display("%0d entries drained, %0d nonzero dropped-count reads, %0d mismatches",
                 board.entries_out, board.dropped_reads, board.errors);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("overwriting_event_ring_buffer_unit verification clean");
        end else begin
            $display("overwriting_event_ring_buffer_unit verification failed");
        end
        $finish;
    end

endmodule
